[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define LAV_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent at one edge implies the consequent at the next edge.
`define LAV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/lav_pkg.sv]
package lav_pkg;

    localparam int EYE_W      = 32;
    localparam int DZ_W       = EYE_W + 1;
    localparam int AXIS_W     = 18;
    localparam int AXIS_FRAC  = 16;
    localparam int MAG_W      = 30;
    localparam int NORM_TOP   = MAG_W - 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_W     = SUM_W + 1;
    localparam int LEN_W      = MAG_W + 1;
    localparam int NUM_W      = MAG_W + AXIS_FRAC + 2;
    localparam int Q_W        = AXIS_FRAC + 1;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int DIV_STEPS  = Q_W;
    localparam int PRE_STAGES = 4;
    localparam int CRA_W      = EYE_W + AXIS_W + 1;
    localparam int CRB_W      = 2 * AXIS_W + 1;
    localparam int PRD_W      = EYE_W + AXIS_W;
    localparam int DOT_W      = PRD_W + 3;

    typedef enum logic [1:0] {
        ROW_RIGHT = 2'd0,
        ROW_UP    = 2'd1,
        ROW_BACK  = 2'd2
    } t_row;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [ROOT_W-1:0] res;
    } t_root;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0]   q;
    } t_quot;

    typedef struct packed {
        logic [2:0][EYE_W-1:0] eye;
        logic [2:0][EYE_W-1:0] up;
    } t_side_z;

    typedef struct packed {
        logic [2:0][EYE_W-1:0]  eye;
        logic [2:0][AXIS_W-1:0] zn;
        logic                   ok;
    } t_side_x;

    typedef struct packed {
        logic [2:0][EYE_W-1:0]  eye;
        logic [2:0][AXIS_W-1:0] zn;
        logic [2:0][AXIS_W-1:0] xn;
        logic                   ok;
    } t_side_y;

    // One step of the digit-by-digit square root, test bit 4^k.
    function automatic t_root root_step(input t_root a, input int unsigned k);
        t_root             r;
        logic [ROOT_W-1:0] bitv;
        logic [ROOT_W-1:0] trial;
        bitv  = ROOT_W'(1) << (2 * k);
        trial = a.res + bitv;
        if (a.rem >= trial) begin
            r.rem = a.rem - trial;
            r.res = (a.res >> 1) + bitv;
        end else begin
            r.rem = a.rem;
            r.res = a.res >> 1;
        end
        return r;
    endfunction

    // One restoring division step, quotient bit p.
    function automatic t_quot div_step(input t_quot a, input logic [LEN_W-1:0] len,
                                       input int unsigned p);
        t_quot            r;
        logic [NUM_W-1:0] d;
        d = NUM_W'(len) << p;
        r = a;
        if (a.rem >= d) begin
            r.rem = a.rem - d;
            r.q   = a.q | (Q_W'(1) << p);
        end
        return r;
    endfunction

endpackage

[src/lav_cross.sv]
module lav_cross #(
    parameter int A_W    = 32,
    parameter int B_W    = 18,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [A_W-1:0] i_a [3],
    input  logic signed [B_W-1:0] i_b [3],
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic signed [A_W+B_W:0] o_vec [3],
    output logic [SIDE_W-1:0]     o_side
);
    import lav_pkg::*;

    localparam int P_W = A_W + B_W;
    localparam int R_W = P_W + 1;

    logic signed [P_W-1:0] r_p [6];
    logic signed [P_W-1:0] n_p [6];
    logic signed [R_W-1:0] r_v [3];
    logic [1:0]            r_vld;
    logic [SIDE_W-1:0]     r_sd0;
    logic [SIDE_W-1:0]     r_sd1;

    always_comb begin
        n_p[0] = P_W'(i_a[1]) * P_W'(i_b[2]);
        n_p[1] = P_W'(i_a[2]) * P_W'(i_b[1]);
        n_p[2] = P_W'(i_a[2]) * P_W'(i_b[0]);
        n_p[3] = P_W'(i_a[0]) * P_W'(i_b[2]);
        n_p[4] = P_W'(i_a[0]) * P_W'(i_b[1]);
        n_p[5] = P_W'(i_a[1]) * P_W'(i_b[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= n_p;
            r_sd0  <= i_side;
            r_v[0] <= R_W'(r_p[0]) - R_W'(r_p[1]);
            r_v[1] <= R_W'(r_p[2]) - R_W'(r_p[3]);
            r_v[2] <= R_W'(r_p[4]) - R_W'(r_p[5]);
            r_sd1  <= r_sd0;
        end
    end

    assign o_valid = r_vld[1];
    assign o_vec   = r_v;
    assign o_side  = r_sd1;

endmodule

[src/lav_norm.sv]
module lav_norm #(
    parameter int VEC_W  = 33,
    parameter int SIDE_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [VEC_W-1:0] i_vec [3],
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic signed [lav_pkg::AXIS_W-1:0] o_axis [3],
    output logic                    o_ok,
    output logic [SIDE_W-1:0]       o_side
);
    import lav_pkg::*;

    localparam int POS_W = $clog2(VEC_W);
    localparam int SH_W  = VEC_W + MAG_W;
    localparam int LAT   = PRE_STAGES + SQRT_STEPS + DIV_STEPS + 1;

    // front end: magnitude, scale, squares, sum
    logic [2:0][VEC_W-1:0] n0_mag, r0_mag;
    logic [2:0]            n0_neg, r0_neg;
    logic [VEC_W-1:0]      n0_or;
    logic [POS_W-1:0]      n0_pos, r0_pos;
    logic                  r0_nz;
    logic [2:0][MAG_W-1:0] n1_m, r1_m, r2_m, r3_m;
    logic [SH_W-1:0]       wide;
    logic [2:0]            r1_neg, r2_neg, r3_neg;
    logic                  r1_nz, r2_nz, r3_nz;
    logic [2:0][SQ_W-1:0]  r2_sq;
    logic [SUM_W-1:0]      r3_sum;

    // square root stages
    t_root                 n_sq [SQRT_STEPS];
    t_root                 r_sq [SQRT_STEPS];
    logic [2:0][MAG_W-1:0] r_sq_m [SQRT_STEPS];
    logic [2:0]            r_sq_neg [SQRT_STEPS];
    logic                  r_sq_nz [SQRT_STEPS];

    // division stages, three components side by side
    logic [LEN_W-1:0]      dv_len0;
    t_quot                 n_dv [DIV_STEPS][3];
    t_quot                 r_dv [DIV_STEPS][3];
    logic [LEN_W-1:0]      r_dv_len [DIV_STEPS];
    logic [2:0]            r_dv_neg [DIV_STEPS];
    logic                  r_dv_nz [DIV_STEPS];

    logic signed [AXIS_W-1:0] r_axis [3];
    logic                     r_ok;
    logic [LAT-1:0]           r_vld;
    logic [SIDE_W-1:0]        r_sd [LAT];

    always_comb begin
        n0_or = '0;
        for (int i = 0; i < 3; i++) begin
            n0_neg[i] = i_vec[i][VEC_W-1];
            n0_mag[i] = n0_neg[i] ? VEC_W'(-i_vec[i]) : VEC_W'(i_vec[i]);
            n0_or     = n0_or | n0_mag[i];
        end
        n0_pos = '0;
        for (int b = 0; b < VEC_W; b++) begin
            if (n0_or[b]) begin
                n0_pos = POS_W'(b);
            end
        end
    end

    // bring the largest magnitude to [2^29, 2^30); right shifts drop bits
    always_comb begin
        wide = '0;
        for (int i = 0; i < 3; i++) begin
            wide = SH_W'(r0_mag[i]);
            if (r0_pos >= POS_W'(NORM_TOP)) begin
                n1_m[i] = MAG_W'(wide >> (r0_pos - POS_W'(NORM_TOP)));
            end else begin
                n1_m[i] = MAG_W'(wide << (POS_W'(NORM_TOP) - r0_pos));
            end
        end
    end

    always_comb begin
        n_sq[0] = root_step(t_root'{rem: ROOT_W'(r3_sum), res: '0}, SQRT_STEPS - 1);
        for (int s = 1; s < SQRT_STEPS; s++) begin
            n_sq[s] = root_step(r_sq[s-1], SQRT_STEPS - 1 - s);
        end
    end

    assign dv_len0 = LEN_W'(r_sq[SQRT_STEPS-1].res);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_dv[0][i] = div_step(
                t_quot'{rem: (NUM_W'(r_sq_m[SQRT_STEPS-1][i]) << AXIS_FRAC)
                             + NUM_W'(dv_len0 >> 1), q: '0},
                dv_len0, DIV_STEPS - 1);
            for (int j = 1; j < DIV_STEPS; j++) begin
                n_dv[j][i] = div_step(r_dv[j-1][i], r_dv_len[j-1], DIV_STEPS - 1 - j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_mag <= n0_mag;
            r0_neg <= n0_neg;
            r0_pos <= n0_pos;
            r0_nz  <= |n0_or;

            r1_m   <= n1_m;
            r1_neg <= r0_neg;
            r1_nz  <= r0_nz;

            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= SQ_W'(r1_m[i]) * SQ_W'(r1_m[i]);
            end
            r2_m   <= r1_m;
            r2_neg <= r1_neg;
            r2_nz  <= r1_nz;

            r3_sum <= SUM_W'(r2_sq[0]) + SUM_W'(r2_sq[1]) + SUM_W'(r2_sq[2]);
            r3_m   <= r2_m;
            r3_neg <= r2_neg;
            r3_nz  <= r2_nz;

            r_sq        <= n_sq;
            r_sq_m[0]   <= r3_m;
            r_sq_neg[0] <= r3_neg;
            r_sq_nz[0]  <= r3_nz;
            for (int s = 1; s < SQRT_STEPS; s++) begin
                r_sq_m[s]   <= r_sq_m[s-1];
                r_sq_neg[s] <= r_sq_neg[s-1];
                r_sq_nz[s]  <= r_sq_nz[s-1];
            end

            r_dv        <= n_dv;
            r_dv_len[0] <= dv_len0;
            r_dv_neg[0] <= r_sq_neg[SQRT_STEPS-1];
            r_dv_nz[0]  <= r_sq_nz[SQRT_STEPS-1];
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_dv_len[j] <= r_dv_len[j-1];
                r_dv_neg[j] <= r_dv_neg[j-1];
                r_dv_nz[j]  <= r_dv_nz[j-1];
            end

            for (int i = 0; i < 3; i++) begin
                r_axis[i] <= r_dv_neg[DIV_STEPS-1][i]
                             ? -AXIS_W'(r_dv[DIV_STEPS-1][i].q)
                             : AXIS_W'(r_dv[DIV_STEPS-1][i].q);
            end
            r_ok <= r_dv_nz[DIV_STEPS-1];

            r_sd[0] <= i_side;
            for (int k = 1; k < LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_axis  = r_axis;
    assign o_ok    = r_ok;
    assign o_side  = r_sd[LAT-1];

endmodule

[src/lav_ofs.sv]
module lav_ofs (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  logic signed [lav_pkg::EYE_W-1:0]  i_eye [3],
    input  logic signed [lav_pkg::AXIS_W-1:0] i_axis [3][3],
    input  logic i_ok,
    output logic o_valid,
    output logic signed [lav_pkg::AXIS_W-1:0] o_axis [3][3],
    output logic signed [lav_pkg::EYE_W-1:0]  o_ofs [3],
    output logic o_ok
);
    import lav_pkg::*;

    localparam logic signed [DOT_W-1:0] HALF = DOT_W'(1) << (AXIS_FRAC - 1);

    logic signed [PRD_W-1:0]  r1_p [3][3];
    logic signed [AXIS_W-1:0] r1_axis [3][3];
    logic                     r1_ok;
    logic signed [DOT_W-1:0]  dot [3];
    logic signed [DOT_W-1:0]  shv [3];
    logic [DOT_W-EYE_W:0]     top [3];
    logic signed [EYE_W-1:0]  n_ofs [3];
    logic signed [AXIS_W-1:0] n_axis [3][3];
    logic signed [AXIS_W-1:0] r2_axis [3][3];
    logic signed [EYE_W-1:0]  r2_ofs [3];
    logic                     r2_ok;
    logic [1:0]               r_vld;

    // negate, round half up by 16 bits, saturate; zero when i_ok is low
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            dot[r] = DOT_W'(r1_p[r][0]) + DOT_W'(r1_p[r][1]) + DOT_W'(r1_p[r][2]);
            shv[r] = (HALF - dot[r]) >>> AXIS_FRAC;
            top[r] = shv[r][DOT_W-1:EYE_W-1];
            if ((&top[r]) || !(|top[r])) begin
                n_ofs[r] = shv[r][EYE_W-1:0];
            end else if (shv[r][DOT_W-1]) begin
                n_ofs[r] = {1'b1, {(EYE_W-1){1'b0}}};
            end else begin
                n_ofs[r] = {1'b0, {(EYE_W-1){1'b1}}};
            end
            for (int c = 0; c < 3; c++) begin
                n_axis[r][c] = r1_ok ? r1_axis[r][c] : '0;
            end
            if (!r1_ok) begin
                n_ofs[r] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_p[r][c] <= PRD_W'(i_axis[r][c]) * PRD_W'(i_eye[c]);
                end
            end
            r1_axis <= i_axis;
            r1_ok   <= i_ok;
            r2_axis <= n_axis;
            r2_ofs  <= n_ofs;
            r2_ok   <= r1_ok;
        end
    end

    assign o_valid = r_vld[1];
    assign o_axis  = r2_axis;
    assign o_ofs   = r2_ofs;
    assign o_ok    = r2_ok;

endmodule

[src/look_at_view_matrix.sv]
// Path: input register, three normalizers joined by two cross products, offset stage
// and row serializer; rows leave it one per cycle while the output side is ready.
// Throughput: the 3-row output serializer takes a new pose only as its last row leaves;
// the pipeline (three 53-stage normalizers) takes an item every cycle when not held.
// Reset: synchronous, active low; clears pipeline valid bits and the serializer.
`include "assert_macros.svh"

module look_at_view_matrix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_eye_x,
    input  logic [31:0] i_eye_y,
    input  logic [31:0] i_eye_z,
    input  logic [31:0] i_target_x,
    input  logic [31:0] i_target_y,
    input  logic [31:0] i_target_z,
    input  logic [31:0] i_upvec_x,
    input  logic [31:0] i_upvec_y,
    input  logic [31:0] i_upvec_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_row_index,
    output logic signed [17:0] o_axis_x,
    output logic signed [17:0] o_axis_y,
    output logic signed [17:0] o_axis_z,
    output logic signed [31:0] o_offset,
    output logic        o_degenerate,
    output logic        o_last_row
);
    import lav_pkg::*;

    logic en;
    logic ser_free;

    // input stage
    logic                   r_in_v;
    t_side_z                r_sz;
    logic signed [DZ_W-1:0] r_dz [3];

    // back axis
    logic                     z_v, z_ok;
    logic signed [AXIS_W-1:0] z_axis [3];
    t_side_z                  z_side;
    logic signed [EYE_W-1:0]  ca_a [3];
    t_side_x                  ca_side_in;

    // right axis
    logic                     ca_v;
    logic signed [CRA_W-1:0]  ca_vec [3];
    t_side_x                  ca_side;
    logic                     x_v, x_ok;
    logic signed [AXIS_W-1:0] x_axis [3];
    t_side_x                  x_side;
    logic signed [AXIS_W-1:0] cb_a [3];
    t_side_y                  cb_side_in;

    // up axis
    logic                     cb_v;
    logic signed [CRB_W-1:0]  cb_vec [3];
    t_side_y                  cb_side;
    logic                     y_v, y_ok;
    logic signed [AXIS_W-1:0] y_axis [3];
    t_side_y                  y_side;

    // translation
    logic signed [EYE_W-1:0]  of_eye [3];
    logic signed [AXIS_W-1:0] of_axis [3][3];
    logic                     t_v, t_ok;
    logic signed [AXIS_W-1:0] t_axis [3][3];
    logic signed [EYE_W-1:0]  t_ofs [3];

    // row serializer
    logic                     r_busy;
    t_row                     r_row;
    t_row                     n_row;
    logic signed [AXIS_W-1:0] r_sr_axis [3][3];
    logic signed [EYE_W-1:0]  r_sr_ofs [3];
    logic                     r_sr_dgn;

    // the whole pipeline moves together; hold when the last stage cannot unload
    assign ser_free   = !r_busy || (i_out_ready && (r_row == ROW_BACK));
    assign en         = !t_v || ser_free;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sz.eye <= {i_eye_z, i_eye_y, i_eye_x};
            r_sz.up  <= {i_upvec_z, i_upvec_y, i_upvec_x};
            r_dz[0]  <= DZ_W'($signed(i_eye_x)) - DZ_W'($signed(i_target_x));
            r_dz[1]  <= DZ_W'($signed(i_eye_y)) - DZ_W'($signed(i_target_y));
            r_dz[2]  <= DZ_W'($signed(i_eye_z)) - DZ_W'($signed(i_target_z));
        end
    end

    lav_norm #(
        .VEC_W  (DZ_W),
        .SIDE_W ($bits(t_side_z))
    ) u_norm_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_v),
        .i_vec   (r_dz),
        .i_side  (r_sz),
        .o_valid (z_v),
        .o_axis  (z_axis),
        .o_ok    (z_ok),
        .o_side  (z_side)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ca_a[i]          = $signed(z_side.up[i]);
            ca_side_in.zn[i] = z_axis[i];
        end
        ca_side_in.eye = z_side.eye;
        ca_side_in.ok  = z_ok;
    end

    lav_cross #(
        .A_W    (EYE_W),
        .B_W    (AXIS_W),
        .SIDE_W ($bits(t_side_x))
    ) u_cross_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (z_v),
        .i_a     (ca_a),
        .i_b     (z_axis),
        .i_side  (ca_side_in),
        .o_valid (ca_v),
        .o_vec   (ca_vec),
        .o_side  (ca_side)
    );

    lav_norm #(
        .VEC_W  (CRA_W),
        .SIDE_W ($bits(t_side_x))
    ) u_norm_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ca_v),
        .i_vec   (ca_vec),
        .i_side  (ca_side),
        .o_valid (x_v),
        .o_axis  (x_axis),
        .o_ok    (x_ok),
        .o_side  (x_side)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cb_a[i]          = $signed(x_side.zn[i]);
            cb_side_in.xn[i] = x_axis[i];
        end
        cb_side_in.eye = x_side.eye;
        cb_side_in.zn  = x_side.zn;
        cb_side_in.ok  = x_side.ok && x_ok;
    end

    lav_cross #(
        .A_W    (AXIS_W),
        .B_W    (AXIS_W),
        .SIDE_W ($bits(t_side_y))
    ) u_cross_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (x_v),
        .i_a     (cb_a),
        .i_b     (x_axis),
        .i_side  (cb_side_in),
        .o_valid (cb_v),
        .o_vec   (cb_vec),
        .o_side  (cb_side)
    );

    lav_norm #(
        .VEC_W  (CRB_W),
        .SIDE_W ($bits(t_side_y))
    ) u_norm_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cb_v),
        .i_vec   (cb_vec),
        .i_side  (cb_side),
        .o_valid (y_v),
        .o_axis  (y_axis),
        .o_ok    (y_ok),
        .o_side  (y_side)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            of_eye[i]     = $signed(y_side.eye[i]);
            of_axis[0][i] = $signed(y_side.xn[i]);
            of_axis[1][i] = y_axis[i];
            of_axis[2][i] = $signed(y_side.zn[i]);
        end
    end

    lav_ofs u_ofs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (y_v),
        .i_eye   (of_eye),
        .i_axis  (of_axis),
        .i_ok    (y_side.ok && y_ok),
        .o_valid (t_v),
        .o_axis  (t_axis),
        .o_ofs   (t_ofs),
        .o_ok    (t_ok)
    );

    always_comb begin
        case (r_row)
            ROW_RIGHT: n_row = ROW_UP;
            ROW_UP:    n_row = ROW_BACK;
            default:   n_row = ROW_BACK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= ROW_RIGHT;
        end else if (en && t_v) begin
            r_busy <= 1'b1;
            r_row  <= ROW_RIGHT;
        end else if (r_busy && i_out_ready) begin
            if (r_row == ROW_BACK) begin
                r_busy <= 1'b0;
            end else begin
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && t_v) begin
            r_sr_axis <= t_axis;
            r_sr_ofs  <= t_ofs;
            r_sr_dgn  <= !t_ok;
        end
    end

    assign o_out_valid  = r_busy;
    assign o_row_index  = r_row;
    assign o_axis_x     = r_sr_axis[r_row][0];
    assign o_axis_y     = r_sr_axis[r_row][1];
    assign o_axis_z     = r_sr_axis[r_row][2];
    assign o_offset     = r_sr_ofs[r_row];
    assign o_degenerate = r_sr_dgn;
    assign o_last_row   = (r_row == ROW_BACK);

    `LAV_ASSERT_ALWAYS(a_drain_when_empty, r_busy || o_in_ready)
    `LAV_ASSERT_ALWAYS(a_degenerate_zero, !(o_out_valid && o_degenerate) || (o_axis_x == '0 && o_axis_y == '0 && o_axis_z == '0 && o_offset == '0))
    `LAV_ASSERT_NEXT(a_row_advance, o_out_valid && i_out_ready && r_row != ROW_BACK, o_out_valid && r_row == t_row'($past(r_row) + 2'd1))
    `LAV_ASSERT_NEXT(a_new_pose_row0, en && t_v, o_out_valid && r_row == ROW_RIGHT)

endmodule
